FILE: sv/assert_macros.svh
// Assertion macros used by the ATR parser RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/scatr_pkg.sv
// Package for the smart card ATR parser: item types, codes and defaults.
// No dependencies; used by scatr_parser and smart_card_atr_parser_core.
package scatr_pkg;

    // Parameter defaults
    localparam int ATR_BYTES_DEF  = 32;
    localparam int MAX_GROUPS_DEF = 7;

    // Input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_FAIL  = 2'd2;

    // Parse status codes
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_RECEIVE  = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    // Byte roles
    localparam logic [3:0] ROLE_NONE = 4'd0;
    localparam logic [3:0] ROLE_TS   = 4'd1;
    localparam logic [3:0] ROLE_T0   = 4'd2;
    localparam logic [3:0] ROLE_TA   = 4'd3;
    localparam logic [3:0] ROLE_TB   = 4'd4;
    localparam logic [3:0] ROLE_TC   = 4'd5;
    localparam logic [3:0] ROLE_TD   = 4'd6;
    localparam logic [3:0] ROLE_HIST = 4'd7;
    localparam logic [3:0] ROLE_TCK  = 4'd8;

    // Valid TS characters (direct and inverse convention)
    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h3F;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic [1:0] parse_status;
        logic [3:0] byte_role;
        logic [4:0] byte_position;
        logic [5:0] answer_length;
        logic       check_byte_needed;
        logic [3:0] historical_total;
    } out_t;

    // One item presented to the parse step
    typedef struct packed {
        logic en;
        in_t  item;
    } step_t;

endpackage

FILE: sv/smart_card_atr_parser_core.sv
// ATR parser core: from input accept to result valid an item passes the input
// register, then the parse step into the result register.
// Throughput is one item per cycle while the result side is not stalled; the
// parse phase register closes its loop through the combinational parse step.
// Reset: aresetn (synchronous, active low) empties both stages and sets the
// parser to idle with all counters cleared. Depends on scatr_pkg, scatr_parser.
module smart_card_atr_parser_core #(
    parameter int ATR_BYTES  = scatr_pkg::ATR_BYTES_DEF,
    parameter int MAX_GROUPS = scatr_pkg::MAX_GROUPS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  scatr_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output scatr_pkg::out_t  m_data
);
    import scatr_pkg::*;

    logic  in_valid_reg;
    in_t   in_data_reg;
    logic  m_valid_reg;
    out_t  m_data_reg;
    logic  adv;
    step_t step;
    out_t  result;

    // Handshake: result stage advances when empty or taken
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || adv;
    assign step.en   = in_valid_reg && adv;
    assign step.item = in_data_reg;

    scatr_parser #(
        .ATR_BYTES (ATR_BYTES),
        .MAX_GROUPS(MAX_GROUPS)
    ) u_parser (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .result (result)
    );

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (adv) m_valid_reg <= in_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (step.en) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/scatr_parser.sv
// ATR parse state and combinational parse step producing one result per item.
// Depends on scatr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module scatr_parser #(
    parameter int ATR_BYTES  = scatr_pkg::ATR_BYTES_DEF,
    parameter int MAX_GROUPS = scatr_pkg::MAX_GROUPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  scatr_pkg::step_t  step,
    output scatr_pkg::out_t   result
);
    import scatr_pkg::*;

    localparam int CW = $clog2(ATR_BYTES + 1);
    localparam int GW = $clog2(MAX_GROUPS + 2);
    localparam logic [CW-1:0] CNT_LIMIT = CW'(ATR_BYTES);
    localparam logic [GW-1:0] GRP_LIMIT = GW'(MAX_GROUPS);

    // Parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TS    = 3'd1;
    localparam logic [2:0] PH_T0    = 3'd2;
    localparam logic [2:0] PH_IFACE = 3'd3;
    localparam logic [2:0] PH_HIST  = 3'd4;
    localparam logic [2:0] PH_TCK   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;
    localparam logic [2:0] PH_FAIL  = 3'd7;

    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    pend_reg, pend_next;
    logic [3:0]    hleft_reg, hleft_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          tck_reg, tck_next;
    logic [3:0]    hheld_reg, hheld_next;

    logic          active;
    logic          close_grp;
    logic [1:0]    bsel;
    logic [3:0]    pend_clr;
    logic [3:0]    role;
    logic [4:0]    pos;
    logic [7:0]    v;

    // Phase following the interface bytes, from the updated counters
    function automatic logic [2:0] after_iface(input logic [3:0] pend,
                                               input logic [3:0] hleft,
                                               input logic       tck);
        logic [2:0] ph;
        if (pend != 4'd0) ph = PH_IFACE;
        else if (hleft != 4'd0) ph = PH_HIST;
        else if (tck) ph = PH_TCK;
        else ph = PH_DONE;
        return ph;
    endfunction

    assign v      = step.item.byte_value;
    assign active = (phase_reg >= PH_TS) && (phase_reg <= PH_TCK);

    // Lowest pending interface byte among TA, TB, TC; TD otherwise
    always_comb begin
        priority if (pend_reg[0]) bsel = 2'd0;
        else if (pend_reg[1]) bsel = 2'd1;
        else if (pend_reg[2]) bsel = 2'd2;
        else bsel = 2'd3;
    end
    assign pend_clr = pend_reg & ~(4'b0001 << bsel);

    // Parse step
    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        hleft_next = hleft_reg;
        grp_next   = grp_reg;
        cnt_next   = cnt_reg;
        tck_next   = tck_reg;
        hheld_next = hheld_reg;
        role       = ROLE_NONE;
        pos        = 5'd0;
        close_grp  = 1'b0;
        if (step.en) begin
            unique case (step.item.opcode)
                OP_START: begin
                    phase_next = PH_TS;
                    pend_next  = 4'd0;
                    hleft_next = 4'd0;
                    grp_next   = '0;
                    cnt_next   = '0;
                    tck_next   = 1'b0;
                    hheld_next = 4'd0;
                end
                OP_FAIL: begin
                    if (active) begin
                        phase_next = PH_FAIL;
                        cnt_next   = '0;
                    end
                end
                OP_BYTE: begin
                    if (active) begin
                        pos      = 5'(cnt_reg);
                        cnt_next = cnt_reg + 1'b1;
                        unique case (phase_reg)
                            PH_TS: begin
                                role = ROLE_TS;
                                if (v == TS_DIRECT || v == TS_INVERSE) begin
                                    phase_next = PH_T0;
                                end else begin
                                    phase_next = PH_FAIL;
                                    cnt_next   = '0;
                                end
                            end
                            PH_T0: begin
                                role       = ROLE_T0;
                                hheld_next = v[3:0];
                                hleft_next = v[3:0];
                                pend_next  = v[7:4];
                                phase_next = after_iface(v[7:4], v[3:0], tck_reg);
                                close_grp  = (v[7:4] == 4'd0);
                            end
                            PH_IFACE: begin
                                role = ROLE_TA + {2'b00, bsel};
                                if (bsel == 2'd3) begin
                                    // TD: protocol nibble and next bitmap
                                    tck_next  = tck_reg | (v[3:0] != 4'd0);
                                    pend_next = v[7:4];
                                    close_grp = 1'b1;
                                end else begin
                                    pend_next = pend_clr;
                                    close_grp = (pend_clr == 4'd0);
                                end
                                phase_next = after_iface(pend_next, hleft_reg, tck_next);
                            end
                            PH_HIST: begin
                                role       = ROLE_HIST;
                                hleft_next = hleft_reg - 1'b1;
                                if (hleft_next == 4'd0) begin
                                    phase_next = tck_reg ? PH_TCK : PH_DONE;
                                end
                            end
                            default: begin
                                role       = ROLE_TCK;
                                phase_next = PH_DONE;
                            end
                        endcase
                        // Group limit
                        if (close_grp) begin
                            grp_next = grp_reg + 1'b1;
                            if (grp_next > GRP_LIMIT) begin
                                phase_next = PH_FAIL;
                                cnt_next   = '0;
                            end
                        end
                        // Buffer limit with more bytes still expected
                        if (phase_next != PH_FAIL && phase_next != PH_DONE &&
                            cnt_next >= CNT_LIMIT) begin
                            phase_next = PH_FAIL;
                            cnt_next   = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result for this item
    always_comb begin
        unique case (phase_next)
            PH_IDLE: result.parse_status = ST_IDLE;
            PH_DONE: result.parse_status = ST_COMPLETE;
            PH_FAIL: result.parse_status = ST_FAILED;
            default: result.parse_status = ST_RECEIVE;
        endcase
        result.byte_role         = role;
        result.byte_position     = pos;
        result.answer_length     = 6'(cnt_next);
        result.check_byte_needed = tck_next;
        result.historical_total  = hheld_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pend_reg  <= 4'd0;
            hleft_reg <= 4'd0;
            grp_reg   <= '0;
            cnt_reg   <= '0;
            tck_reg   <= 1'b0;
            hheld_reg <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            hleft_reg <= hleft_next;
            grp_reg   <= grp_next;
            cnt_reg   <= cnt_next;
            tck_reg   <= tck_next;
            hheld_reg <= hheld_next;
        end
    end

    // Assertions
    `ASSERT_SAME(a_fail_clears_len, aclk, aresetn, phase_reg == PH_FAIL, cnt_reg == '0, "failed parse holds bytes")
    `ASSERT_SAME(a_cnt_bound, aclk, aresetn, cnt_reg >= CNT_LIMIT, phase_reg == PH_DONE, "byte count beyond buffer")
    `ASSERT_SAME(a_iface_pending, aclk, aresetn, phase_reg == PH_IFACE, pend_reg != 4'd0, "interface phase with no bits")
    `ASSERT_NEXT(a_start, aclk, aresetn, step.en && step.item.opcode == OP_START, phase_reg == PH_TS && cnt_reg == '0 && grp_reg == '0, "start did not restart")

endmodule

FILE: bench/scatr_atr_checker.sv
`timescale 1ns / 1ps
// Checker for the smart card ATR parser: watches both channels, predicts every result
// from the accepted items and compares them field by field. Depends on scatr_pkg.
module scatr_atr_checker #(
    parameter int ATR_BYTES  = scatr_pkg::ATR_BYTES_DEF,
    parameter int MAX_GROUPS = scatr_pkg::MAX_GROUPS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  scatr_pkg::in_t   s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  scatr_pkg::out_t  m_data,
    output int               fail_count,
    output int               pending_results,
    output int               items_accepted,
    output int               results_checked,
    output int               answers_done,
    output int               parses_failed
);
    import scatr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_TS, PH_T0, PH_IFACE, PH_HIST, PH_TCK, PH_DONE, PH_FAIL
    } atr_phase_e;

    // Predicted parser state
    atr_phase_e  phase;
    logic [3:0]  iface_bits;
    logic [3:0]  hist_left;
    logic [3:0]  hist_total;
    int          group_count;
    int          byte_count;
    logic        tck_needed;

    out_t        expected_results[$];

    function automatic void clear_parser();
        phase       = PH_IDLE;
        iface_bits  = 4'd0;
        hist_left   = 4'd0;
        hist_total  = 4'd0;
        group_count = 0;
        byte_count  = 0;
        tck_needed  = 1'b0;
    endfunction

    function automatic bit answer_open();
        return phase >= PH_TS && phase <= PH_TCK;
    endfunction

    function automatic void abort_answer();
        phase      = PH_FAIL;
        byte_count = 0;
    endfunction

    // More interface bytes, then historical bytes, then TCK if any protocol was not zero
    function automatic atr_phase_e phase_after_iface();
        if (iface_bits != 4'd0) return PH_IFACE;
        if (hist_left != 4'd0) return PH_HIST;
        if (tck_needed) return PH_TCK;
        return PH_DONE;
    endfunction

    function automatic void close_group();
        group_count++;
        if (group_count > MAX_GROUPS) abort_answer();
    endfunction

    // Advance the predicted parser by one item and return the result it should give
    function automatic out_t atr_predict_step(input in_t item);
        logic [3:0] role;
        logic [7:0] v;
        int         pos;
        int         b;
        bit         group_done;
        out_t       r;
        role       = ROLE_NONE;
        v          = item.byte_value;
        pos        = 0;
        group_done = 1'b0;
        if (item.opcode == OP_START) begin
            clear_parser();
            phase = PH_TS;
        end else if (item.opcode == OP_FAIL) begin
            if (answer_open()) abort_answer();
        end else if (item.opcode == OP_BYTE && answer_open()) begin
            pos = byte_count;
            byte_count++;
            case (phase)
                PH_TS: begin
                    role = ROLE_TS;
                    if (v == TS_DIRECT || v == TS_INVERSE) phase = PH_T0;
                    else abort_answer();
                end
                PH_T0: begin
                    role       = ROLE_T0;
                    hist_total = v[3:0];
                    hist_left  = v[3:0];
                    iface_bits = v[7:4];
                    phase      = phase_after_iface();
                    // a zero bitmap still counts as one finished group
                    if (iface_bits == 4'd0) close_group();
                end
                PH_IFACE: begin
                    // lowest pending bit decides between TA, TB, TC and TD
                    b = 0;
                    while (b < 3 && !iface_bits[2'(b)]) b++;
                    role                = ROLE_TA + 4'(b);
                    iface_bits[2'(b)]   = 1'b0;
                    if (b == 3) begin
                        if (v[3:0] != 4'd0) tck_needed = 1'b1;
                        iface_bits = v[7:4];
                        group_done = 1'b1;
                    end else if (iface_bits == 4'd0) begin
                        group_done = 1'b1;
                    end
                    phase = phase_after_iface();
                    if (group_done) close_group();
                end
                PH_HIST: begin
                    role      = ROLE_HIST;
                    hist_left = hist_left - 4'd1;
                    if (hist_left == 4'd0) phase = tck_needed ? PH_TCK : PH_DONE;
                end
                default: begin
                    role  = ROLE_TCK;
                    phase = PH_DONE;
                end
            endcase
            // buffer full while more bytes are still due
            if (phase != PH_FAIL && phase != PH_DONE && byte_count >= ATR_BYTES)
                abort_answer();
        end

        case (phase)
            PH_IDLE: r.parse_status = ST_IDLE;
            PH_DONE: r.parse_status = ST_COMPLETE;
            PH_FAIL: r.parse_status = ST_FAILED;
            default: r.parse_status = ST_RECEIVE;
        endcase
        r.byte_role         = role;
        r.byte_position     = 5'(pos);
        r.answer_length     = 6'(byte_count);
        r.check_byte_needed = tck_needed;
        r.historical_total  = hist_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    // Compare each result with the oldest prediction, then predict for a new item
    always @(posedge aclk) begin
        out_t       want;
        atr_phase_e was_phase;
        if (!aresetn) begin
            clear_parser();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_checked));
                end else begin
                    want = expected_results.pop_front();
                    check_field("parse_status", 8'(m_data.parse_status),
                                8'(want.parse_status));
                    check_field("byte_role", 8'(m_data.byte_role), 8'(want.byte_role));
                    check_field("byte_position", 8'(m_data.byte_position),
                                8'(want.byte_position));
                    check_field("answer_length", 8'(m_data.answer_length),
                                8'(want.answer_length));
                    check_field("check_byte_needed", 8'(m_data.check_byte_needed),
                                8'(want.check_byte_needed));
                    check_field("historical_total", 8'(m_data.historical_total),
                                8'(want.historical_total));
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                was_phase = phase;
                expected_results.push_back(atr_predict_step(s_data));
                items_accepted++;
                if (phase != was_phase && phase == PH_DONE) answers_done++;
                if (phase != was_phase && phase == PH_FAIL) parses_failed++;
            end
        end
        pending_results = expected_results.size();
    end

endmodule

FILE: bench/tb_smart_card_atr_parser_core.sv
`timescale 1ns / 1ps
// Testbench top for smart_card_atr_parser_core: drives start, byte, failure and unused items
// and gives the verdict. Depends on scatr_pkg, the core RTL and scatr_atr_checker.
module tb_smart_card_atr_parser_core;
    import scatr_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 800;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 10;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    logic  steady;          // no idling on either side while set
    int    items_sent;
    int    stall_cycles;
    int    fail_count;
    int    pending_results;
    int    items_accepted;
    int    results_checked;
    int    answers_done;
    int    parses_failed;

    smart_card_atr_parser_core #(
        .ATR_BYTES  (ATR_BYTES_DEF),
        .MAX_GROUPS (MAX_GROUPS_DEF)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    scatr_atr_checker #(
        .ATR_BYTES  (ATR_BYTES_DEF),
        .MAX_GROUPS (MAX_GROUPS_DEF)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .items_accepted  (items_accepted),
        .results_checked (results_checked),
        .answers_done    (answers_done),
        .parses_failed   (parses_failed)
    );

    always #1 aclk = ~aclk;

    // Result side stalls now and then
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // Stop the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    // One item, with an optional gap first; returns just after the accepting edge
    task automatic drive_item(input logic [1:0] op, input logic [7:0] value,
                              input bit counted);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {op, value};
        do @(posedge aclk); while (!s_ready);
        if (counted) items_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    function automatic logic [3:0] random_map(input bit more);
        return {more, 3'($urandom)};
    endfunction

    // Well-formed answer with random content, sometimes broken or cut short
    task automatic send_answer();
        logic [7:0] chars[$];
        logic [3:0] map;
        logic [3:0] proto;
        int         n_groups;
        int         hist;
        int         fail_at;
        int         cut;
        bit         need_tck;
        // mostly short chains, sometimes long enough for the group or buffer limit
        n_groups = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 3);
        hist     = ($urandom_range(0, 7) == 0) ? 15 : $urandom_range(0, 5);
        need_tck = 1'b0;
        map      = random_map(n_groups > 1);
        if ($urandom_range(0, 19) == 0) chars.push_back(8'($urandom));
        else chars.push_back($urandom_range(0, 1) ? TS_DIRECT : TS_INVERSE);
        chars.push_back({map, 4'(hist)});
        for (int g = 1; map != 4'd0; g++) begin
            for (int b = 0; b < 3; b++)
                if (map[b]) chars.push_back(8'($urandom));
            if (map[3]) begin
                proto    = $urandom_range(0, 1) ? 4'd0 : 4'($urandom);
                need_tck = need_tck || (proto != 4'd0);
                map      = random_map(g + 1 < n_groups);
                chars.push_back({map, proto});
            end else begin
                map = 4'd0;
            end
        end
        repeat (hist) chars.push_back(8'($urandom));
        if (need_tck && $urandom_range(0, 15) != 0) chars.push_back(8'($urandom));

        fail_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, chars.size() - 1) : -1;
        cut     = ($urandom_range(0, 19) == 0) ? $urandom_range(1, chars.size()) : chars.size();
        drive_item(OP_START, 8'($urandom), 1'b1);
        for (int i = 0; i < cut; i++)
            drive_item((i == fail_at) ? OP_FAIL : OP_BYTE, chars[i], 1'b1);
        // a stray character after the answer
        if ($urandom_range(0, 7) == 0) drive_item(OP_BYTE, 8'($urandom), 1'b0);
    endtask

    // Short runs of arbitrary items, opcodes weighted toward bytes
    task automatic send_noise();
        logic [1:0] op;
        int         n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) drive_item(OP_START, 8'($urandom), 1'b1);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       op = OP_START;
                1:       op = OP_FAIL;
                2:       op = OP_UNUSED;
                default: op = OP_BYTE;
            endcase
            drive_item(op, 8'($urandom), 1'b1);
        end
    endtask

    initial begin
        int first_random;
        bit drained_once;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        steady       = 1'b0;
        items_sent   = 0;
        stall_cycles = 0;
        drained_once = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes, failures and the unused opcode while idle are ignored
        drive_item(OP_BYTE, 8'hFF, 1'b1);
        drive_item(OP_UNUSED, 8'h00, 1'b1);
        drive_item(OP_FAIL, 8'h5A, 1'b1);
        // shortest answer: TS and a T0 with no interface or historical bytes, then a stray byte
        drive_item(OP_START, 8'h00, 1'b1);
        drive_item(OP_BYTE, TS_DIRECT, 1'b1);
        drive_item(OP_BYTE, 8'h00, 1'b1);
        drive_item(OP_BYTE, 8'hFF, 1'b1);
        // all four interface bytes, protocol one, one historical byte and TCK
        drive_item(OP_START, 8'hFF, 1'b1);
        drive_item(OP_BYTE, TS_INVERSE, 1'b1);
        drive_item(OP_BYTE, 8'hF1, 1'b1);
        drive_item(OP_BYTE, 8'h00, 1'b1);
        drive_item(OP_BYTE, 8'hFF, 1'b1);
        drive_item(OP_BYTE, 8'h55, 1'b1);
        drive_item(OP_BYTE, 8'h01, 1'b1);
        drive_item(OP_BYTE, 8'hAA, 1'b1);
        drive_item(OP_BYTE, 8'h12, 1'b1);
        // bad TS fails, and a receive failure after that is ignored
        drive_item(OP_START, 8'h00, 1'b1);
        drive_item(OP_BYTE, 8'h00, 1'b1);
        drive_item(OP_FAIL, 8'h00, 1'b1);
        // receive failure in the middle of an answer
        drive_item(OP_START, 8'h00, 1'b1);
        drive_item(OP_BYTE, TS_DIRECT, 1'b1);
        drive_item(OP_FAIL, 8'hFF, 1'b1);

        // random part: mostly well-formed answers, some noise
        first_random = items_sent;
        while (items_sent < first_random + RANDOM_ITEMS) begin
            steady = (items_sent >= first_random + 400) && (items_sent < first_random + 550);
            if (!drained_once && items_sent >= first_random + 300) begin
                wait_for_results();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_answer();
        end

        steady = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Summary: %0d items in, %0d results checked, %0d mismatches",
                 items_accepted, results_checked, fail_count);
        $display("Answers parsed to completion: %0d, parses ending in failure: %0d",
                 answers_done, parses_failed);
        if (fail_count == 0 && pending_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
